// ===== hdl/gls_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gls_pkg
// Shared types and constants of the grid led shadow and serial codec.
// ----------------------------------------------------------------------------
package gls_pkg;

    // operation codes of an input word
    typedef enum logic [2:0] {
        OP_SET_LED   = 3'd0,
        OP_TOGGLE    = 3'd1,
        OP_SET_ROW   = 3'd2,
        OP_SET_COL   = 3'd3,
        OP_REDRAW    = 3'd4,
        OP_INTENSITY = 3'd5,
        OP_SHUTDOWN  = 3'd6,
        OP_RX_BYTE   = 3'd7
    } op_t;

    // command nibbles of the serial protocol
    localparam logic [3:0] CMD_PRESS     = 4'h0;
    localparam logic [3:0] CMD_LED       = 4'h2;
    localparam logic [3:0] CMD_INTENSITY = 4'h3;
    localparam logic [3:0] CMD_SHUTDOWN  = 4'h6;
    localparam logic [3:0] CMD_ROW       = 4'h7;
    localparam logic [3:0] CMD_COLUMN    = 4'h8;

    // result kinds
    localparam logic KIND_MSG   = 1'b0;
    localparam logic KIND_PRESS = 1'b1;

    // one result word, without the last flag
    typedef struct packed {
        logic       kind;
        logic [7:0] first_byte;
        logic [7:0] second_byte;
        logic [3:0] press_x;
        logic [3:0] press_y;
        logic [3:0] press_state;
    } res_t;

    // outputs of the shared bit update unit
    typedef struct packed {
        logic [7:0] new_row;
        logic       cur_bit;
        logic       new_bit;
        logic       changed;
    } bit_res_t;

endpackage
`default_nettype wire

// ===== hdl/grid_led_shadow_and_serial_codec.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grid_led_shadow_and_serial_codec
// Host side of an 8x8 button-grid serial link: led shadow, message encoder
// and received-frame decoder, run by a small sequencer around one bit unit.
// ----------------------------------------------------------------------------
//  channel  handshake             payload
//  in       in_valid / in_ready   op, x_pos, y_pos, value
//  out      out_valid / out_ready kind, first_byte, second_byte, press_x,
//                                 press_y, press_state, last
//
//  rx bytes and set row/intensity/shutdown are taken in idle, any result
//  being loaded from the emit state; set/toggle led reads the row, then
//  updates it; set column reads and writes each row, redraw reads and emits
//  each row, rows = min(GRID_ROWS, 8); the shadow has one registered read port.
//  in_ready is high only while the sequencer is idle.
//  reset clears the sequencer, rx framing and the shadow valid bits at once.
//  a stalled out_ready holds any emitting state in place, nothing is dropped.
// ----------------------------------------------------------------------------
module grid_led_shadow_and_serial_codec
    import gls_pkg::*;
#(
    parameter int GRID_ROWS = 8
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [2:0] op,
    input  wire logic [2:0] x_pos,
    input  wire logic [2:0] y_pos,
    input  wire logic [7:0] value,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic            kind,
    output logic      [7:0] first_byte,
    output logic      [7:0] second_byte,
    output logic      [3:0] press_x,
    output logic      [3:0] press_y,
    output logic      [3:0] press_state,
    output logic            last
);

    // only rows a 3-bit index can reach are stored
    localparam int ROW_COUNT = (GRID_ROWS < 8) ? GRID_ROWS : 8;
    localparam int ROW_AW    = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
    localparam logic [4:0]        GRID_LIM = 5'(GRID_ROWS);
    localparam logic [ROW_AW-1:0] LAST_ROW = ROW_AW'(ROW_COUNT - 1);

    // sequencer states
    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_LED      = 7'b0000010,
        ST_COL_RD   = 7'b0000100,
        ST_COL_WR   = 7'b0001000,
        ST_DRAW_RD  = 7'b0010000,
        ST_DRAW_OUT = 7'b0100000,
        ST_EMIT     = 7'b1000000
    } state_t;

    state_t            state_reg, state_next;
    op_t               op_in;
    op_t               op_reg, op_next;
    logic [2:0]        x_reg, x_next;
    logic [2:0]        y_reg, y_next;
    logic [7:0]        val_reg, val_next;
    logic [ROW_AW-1:0] cnt_reg, cnt_next;
    res_t              res_reg, res_next;
    logic              phase_reg, phase_next;
    logic [7:0]        held_reg, held_next;

    // output register
    logic              out_valid_reg, out_valid_next;
    res_t              out_reg, out_next;
    logic              out_last_reg, out_last_next;
    logic              out_free;
    logic              out_load;

    // shadow memory ports
    logic              wr_en;
    logic [ROW_AW-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [ROW_AW-1:0] rd_addr;
    logic [7:0]        rd_data;

    // shared bit unit
    logic              bu_toggle;
    logic              bu_set;
    bit_res_t          bu_res;

    logic              accept;
    logic              y_in_ok;
    logic              col_bit;

    assign op_in    = op_t'(op);
    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign y_in_ok  = ({2'b00, y_pos} < GRID_LIM);
    assign out_free = !out_valid_reg || out_ready;
    assign col_bit  = val_reg[3'(cnt_reg)];

    gls_shadow #(
        .ROWS (ROW_COUNT)
    ) u_shadow (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // set/toggle led and set column share this unit
    assign bu_toggle = (state_reg == ST_LED) && (op_reg == OP_TOGGLE);
    assign bu_set    = (state_reg == ST_LED) ? val_reg[0] : col_bit;

    gls_bit_unit u_bit (
        .row     (rd_data),
        .idx     (x_reg),
        .toggle  (bu_toggle),
        .set_val (bu_set),
        .res     (bu_res)
    );

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        val_next       = val_reg;
        cnt_next       = cnt_reg;
        res_next       = res_reg;
        phase_next     = phase_reg;
        held_next      = held_reg;
        out_load       = 1'b0;
        out_next       = out_reg;
        out_last_next  = out_last_reg;
        wr_en          = 1'b0;
        wr_addr        = y_pos[ROW_AW-1:0];
        wr_data        = value;
        rd_en          = 1'b0;
        rd_addr        = y_pos[ROW_AW-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next  = op_in;
                    x_next   = x_pos;
                    y_next   = y_pos;
                    val_next = value;
                    cnt_next = '0;
                    res_next = '{kind: KIND_MSG, first_byte: 8'h00,
                                 second_byte: value, press_x: 4'h0,
                                 press_y: 4'h0, press_state: 4'h0};
                    unique case (op_in)
                        OP_SET_LED, OP_TOGGLE:
                        begin
                            // rows beyond the grid: nothing to do
                            if (y_in_ok)
                            begin
                                rd_en      = 1'b1;
                                state_next = ST_LED;
                            end
                        end
                        OP_SET_ROW:
                        begin
                            wr_en               = y_in_ok;
                            res_next.first_byte = {CMD_ROW, 1'b0, y_pos};
                            state_next          = ST_EMIT;
                        end
                        OP_SET_COL:
                        begin
                            state_next = ST_COL_RD;
                        end
                        OP_REDRAW:
                        begin
                            state_next = ST_DRAW_RD;
                        end
                        OP_INTENSITY:
                        begin
                            res_next.first_byte = {CMD_INTENSITY, 4'h0};
                            state_next          = ST_EMIT;
                        end
                        OP_SHUTDOWN:
                        begin
                            res_next.first_byte = {CMD_SHUTDOWN, 4'h0};
                            state_next          = ST_EMIT;
                        end
                        OP_RX_BYTE:
                        begin
                            if (!phase_reg)
                            begin
                                // first byte of a frame is only held
                                phase_next = 1'b1;
                                held_next  = value;
                            end
                            else
                            begin
                                phase_next = 1'b0;
                                // only address zero frames are press events
                                if (held_reg[7:4] == CMD_PRESS)
                                begin
                                    res_next = '{kind: KIND_PRESS,
                                                 first_byte: held_reg,
                                                 second_byte: value,
                                                 press_x: value[7:4],
                                                 press_y: value[3:0],
                                                 press_state: held_reg[3:0]};
                                    state_next = ST_EMIT;
                                end
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_LED:
            begin
                if (!bu_res.changed)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    wr_en         = 1'b1;
                    wr_addr       = y_reg[ROW_AW-1:0];
                    wr_data       = bu_res.new_row;
                    out_load      = 1'b1;
                    out_next      = '{kind: KIND_MSG,
                                      first_byte: {CMD_LED, 3'b000, bu_res.new_bit},
                                      second_byte: {1'b0, x_reg, 1'b0, y_reg},
                                      press_x: 4'h0, press_y: 4'h0,
                                      press_state: 4'h0};
                    out_last_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end

            ST_COL_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = cnt_reg;
                state_next = ST_COL_WR;
            end

            ST_COL_WR:
            begin
                wr_en   = 1'b1;
                wr_addr = cnt_reg;
                wr_data = bu_res.new_row;
                if (cnt_reg == LAST_ROW)
                begin
                    res_next.first_byte = {CMD_COLUMN, 1'b0, x_reg};
                    state_next          = ST_EMIT;
                end
                else
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = ST_COL_RD;
                end
            end

            ST_DRAW_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = cnt_reg;
                state_next = ST_DRAW_OUT;
            end

            ST_DRAW_OUT:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    out_next      = '{kind: KIND_MSG,
                                      first_byte: {CMD_ROW, 4'(cnt_reg)},
                                      second_byte: rd_data,
                                      press_x: 4'h0, press_y: 4'h0,
                                      press_state: 4'h0};
                    out_last_next = (cnt_reg == LAST_ROW);
                    if (cnt_reg == LAST_ROW)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg + 1'b1;
                        state_next = ST_DRAW_RD;
                    end
                end
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    out_next      = res_reg;
                    out_last_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = out_load || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= 1'b0;
            held_reg      <= 8'h00;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            held_reg      <= held_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        val_reg      <= val_next;
        res_reg      <= res_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid   = out_valid_reg;
    assign kind        = out_reg.kind;
    assign first_byte  = out_reg.first_byte;
    assign second_byte = out_reg.second_byte;
    assign press_x     = out_reg.press_x;
    assign press_y     = out_reg.press_y;
    assign press_state = out_reg.press_state;
    assign last        = out_last_reg;

endmodule
`default_nettype wire

// ===== hdl/gls_bit_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gls_bit_unit
// Shared read-modify unit: sets or toggles one bit of a row byte.
// ----------------------------------------------------------------------------
module gls_bit_unit
    import gls_pkg::*;
(
    input  wire logic [7:0] row,
    input  wire logic [2:0] idx,
    input  wire logic       toggle,
    input  wire logic       set_val,
    output bit_res_t        res
);

    logic cur;
    logic nb;

    always_comb
    begin
        cur         = row[idx];
        nb          = toggle ? ~cur : set_val;
        res.cur_bit = cur;
        res.new_bit = nb;
        res.changed = (cur != nb);
        res.new_row = (row & ~(8'b1 << idx)) | (8'(nb) << idx);
    end

endmodule
`default_nettype wire

// ===== hdl/gls_shadow.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gls_shadow
// LED shadow memory: one byte per row, one write and one registered read port.
// ----------------------------------------------------------------------------
module gls_shadow
    import gls_pkg::*;
#(
    parameter int ROWS = 8
)
(
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   wr_en,
    input  wire logic [((ROWS > 1) ? $clog2(ROWS) : 1)-1:0] wr_addr,
    input  wire logic [7:0]                             wr_data,
    input  wire logic                                   rd_en,
    input  wire logic [((ROWS > 1) ? $clog2(ROWS) : 1)-1:0] rd_addr,
    output logic      [7:0]                             rd_data
);

    logic [7:0]      mem [ROWS];
    logic [ROWS-1:0] vld_reg;
    logic [ROWS-1:0] vld_next;
    logic [7:0]      rdat_reg;
    logic            rvld_reg;

    // entries read as zero until first written
    always_comb
    begin
        vld_next = vld_reg;
        if (wr_en)
        begin
            vld_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            rvld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
            if (rd_en)
            begin
                rvld_reg <= vld_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdat_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rvld_reg ? rdat_reg : 8'h00;

endmodule
`default_nettype wire
